// ===== hdl/r2fft_pkg.sv =====
// Shared constants, types and helper functions of the radix-2 FFT block.
package r2fft_pkg;

   localparam int MAX_POINTS   = 64;
   localparam int TWIDDLE_BITS = 16;

   localparam int PTR_W    = $clog2(MAX_POINTS);
   localparam int LOG2_MAX = PTR_W;
   localparam int LG_W     = $clog2(LOG2_MAX + 1);
   localparam int ROM_LOG2 = 6;

   localparam int SAMPLE_W = 16;
   localparam int STORE_W  = 23;
   localparam int WORD_W   = 2 * STORE_W;
   localparam int REQ_W    = ((2 * SAMPLE_W + 7) / 8) * 8;
   localparam int RSP_W    = ((WORD_W + 7) / 8) * 8;

   localparam int TW_FRAC = TWIDDLE_BITS - 2;
   localparam int MAG_W   = TW_FRAC + 1;
   localparam int PROD_W  = TWIDDLE_BITS + STORE_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int T_W     = SUM_W - TW_FRAC;
   localparam int DIFF_W  = T_W + 1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_LOG2    = 2'd1;
   localparam logic [2:0]           SIZE_RESET       = 3'd6;

   typedef logic [PTR_W-1:0]          ptr_type;
   typedef logic [WORD_W-1:0]         word_type;
   typedef logic signed [STORE_W-1:0] store_type;
   typedef logic signed [TWIDDLE_BITS-1:0] tw_type;

   // Quarter-wave cosine at 2^30 scale, rounded to TW_FRAC fraction bits.
   function automatic logic [MAG_W-1:0] tw_mag(input logic [4:0] k);
      logic [31:0] c;
      case (k)
         5'd0:    c = 32'd1073741824;
         5'd1:    c = 32'd1068571464;
         5'd2:    c = 32'd1053110176;
         5'd3:    c = 32'd1027506862;
         5'd4:    c = 32'd992008094;
         5'd5:    c = 32'd946955747;
         5'd6:    c = 32'd892783698;
         5'd7:    c = 32'd830013654;
         5'd8:    c = 32'd759250125;
         5'd9:    c = 32'd681174602;
         5'd10:   c = 32'd596538995;
         5'd11:   c = 32'd506158392;
         5'd12:   c = 32'd410903207;
         5'd13:   c = 32'd311690799;
         5'd14:   c = 32'd209476638;
         5'd15:   c = 32'd105245103;
         default: c = 32'd0;
      endcase
      return MAG_W'((c + (32'd1 << (29 - TW_FRAC))) >> (30 - TW_FRAC));
   endfunction

   function automatic ptr_type bit_rev(input ptr_type v);
      ptr_type r;
      for (int b = 0; b < PTR_W; b++) begin
         r[b] = v[PTR_W-1-b];
      end
      return r;
   endfunction

   // Clamp a wide signed value into the store range.
   function automatic store_type sat_store(input logic signed [DIFF_W-1:0] v);
      store_type r;
      if (&v[DIFF_W-1:STORE_W-1] || ~|v[DIFF_W-1:STORE_W-1]) begin
         r = v[STORE_W-1:0];
      end else if (v[DIFF_W-1]) begin
         r = {1'b1, {(STORE_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(STORE_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ===== hdl/radix2_complex_fft.sv =====
// Radix-2 decimation-in-time FFT over a 64-entry store with one shared butterfly unit.
// Load: one sample per cycle, written at its bit-reversed address; tready stays high.
// Transform: (N/2)*log2(N) butterflies, each in the steps read, multiply, round, write
//   bottom and write top, through the single write port of the store.
// Output: each bin is read from the store, then presented; N bins in natural order.
// Reset is synchronous, active high; it clears the sequencer, the load position and the
// two registers, not the store.
module radix2_complex_fft (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [r2fft_pkg::REQ_W-1:0]     req_tdata,  // sample_re, sample_im
   input  logic                            req_tlast,  // sample_last
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [r2fft_pkg::RSP_W-1:0]     rsp_tdata,  // bin_re, bin_im, zero pad
   output logic                            rsp_tlast,  // bin_last
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [r2fft_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [r2fft_pkg::CSR_DATA_W-1:0] csr_data
);
   import r2fft_pkg::*;

   // Sequencer states
   localparam logic [2:0] S_LOAD = 3'd0;  // accept samples
   localparam logic [2:0] S_RD   = 3'd1;  // read top and bottom entries, latch twiddle
   localparam logic [2:0] S_MUL  = 3'd2;  // complex multiply of bottom by twiddle
   localparam logic [2:0] S_SUM  = 3'd3;  // add products, round, shift
   localparam logic [2:0] S_WRK  = 3'd4;  // write bottom = top - t
   localparam logic [2:0] S_WRJ  = 3'd5;  // write top = top + t, advance
   localparam logic [2:0] S_ORD  = 3'd6;  // read bin
   localparam logic [2:0] S_OUT  = 3'd7;  // present bin

   logic [2:0]        state_ff, state_in;
   logic              inverse_ff, inverse_in;
   logic [2:0]        size_ff, size_in;
   logic [LG_W-1:0]   lg_ff, lg_in;
   logic [LG_W-1:0]   stage_ff, stage_in;
   ptr_type           pos_ff, pos_in;
   ptr_type           bf_ff, bf_in;
   ptr_type           idx_ff, idx_in;

   word_type          store_mem [MAX_POINTS];
   word_type          rd_a_ff, rd_b_ff;
   tw_type            tw_re_ff, tw_im_ff;
   logic signed [PROD_W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [T_W-1:0]    t_re_ff, t_im_ff;

   logic              req_fire, rsp_fire;
   logic [LG_W-1:0]   frame_lg;
   ptr_type           frame_mask, load_addr;
   ptr_type           hmask, half_bit, bf_n, j_addr, k_addr, last_bf;
   logic [ROM_LOG2-1:0] tw_full;
   logic [4:0]        tw_t;
   logic [MAG_W-1:0]  cos_mag, sin_mag;
   tw_type            tw_re, tw_im, sin_w;
   store_type         xj_re, xj_im, xk_re, xk_im;
   logic signed [SUM_W-1:0] sum_re, sum_im;
   store_type         out_k_re, out_k_im, out_j_re, out_j_im;
   logic              wr_en;
   ptr_type           wr_addr, rd_a_addr;
   word_type          wr_data;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign csr_ready  = 1'b1;
   assign rsp_tdata  = {{(RSP_W-WORD_W){1'b0}}, rd_a_ff};
   assign rsp_tlast  = (idx_ff == frame_mask);

   // Clamp the size register to the supported range.
   always_comb begin
      if (size_ff == 3'd0) begin
         frame_lg = LG_W'(1);
      end else if (size_ff > 3'(LOG2_MAX)) begin
         frame_lg = LG_W'(LOG2_MAX);
      end else begin
         frame_lg = LG_W'(size_ff);
      end
   end

   // Frame mask follows the latched size during the transform and output.
   always_comb begin
      if (state_ff == S_LOAD) begin
         frame_mask = ~({PTR_W{1'b1}} << frame_lg);
      end else begin
         frame_mask = ~({PTR_W{1'b1}} << lg_ff);
      end
   end

   assign load_addr = bit_rev(pos_ff) >> (PTR_W - int'(frame_lg));

   // Butterfly addressing: insert a zero at bit stage-1 for the top index.
   assign hmask    = ~({PTR_W{1'b1}} << (stage_ff - LG_W'(1)));
   assign half_bit = PTR_W'(1) << (stage_ff - LG_W'(1));
   assign bf_n     = bf_ff & hmask;
   assign j_addr   = ((bf_ff & ~hmask) << 1) | bf_n;
   assign k_addr   = j_addr | half_bit;
   assign last_bf  = ~({PTR_W{1'b1}} << (lg_ff - LG_W'(1)));
   assign tw_full  = ROM_LOG2'(bf_n) << (ROM_LOG2 - int'(stage_ff));
   assign tw_t     = tw_full[4:0];

   // Twiddle from the quarter-wave table, sign from the quadrant.
   always_comb begin
      if (tw_t <= 5'd16) begin
         cos_mag = tw_mag(tw_t);
         sin_mag = tw_mag(5'(6'd16 - {1'b0, tw_t}));
         tw_re   = $signed({1'b0, cos_mag});
      end else begin
         cos_mag = tw_mag(5'(6'd32 - {1'b0, tw_t}));
         sin_mag = tw_mag(5'(tw_t - 5'd16));
         tw_re   = -$signed({1'b0, cos_mag});
      end
      sin_w = $signed({1'b0, sin_mag});
      tw_im = inverse_ff ? sin_w : -sin_w;
   end

   assign xj_re = rd_a_ff[STORE_W-1:0];
   assign xj_im = rd_a_ff[WORD_W-1:STORE_W];
   assign xk_re = rd_b_ff[STORE_W-1:0];
   assign xk_im = rd_b_ff[WORD_W-1:STORE_W];

   // Product sums with round-half-up before the floor shift.
   assign sum_re = SUM_W'(p_rr_ff) - SUM_W'(p_ii_ff) + SUM_W'(1 <<< (TW_FRAC - 1));
   assign sum_im = SUM_W'(p_ri_ff) + SUM_W'(p_ir_ff) + SUM_W'(1 <<< (TW_FRAC - 1));

   assign out_k_re = sat_store(DIFF_W'(xj_re) - DIFF_W'(t_re_ff));
   assign out_k_im = sat_store(DIFF_W'(xj_im) - DIFF_W'(t_im_ff));
   assign out_j_re = sat_store(DIFF_W'(xj_re) + DIFF_W'(t_re_ff));
   assign out_j_im = sat_store(DIFF_W'(xj_im) + DIFF_W'(t_im_ff));

   // Store write and read port selection.
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = load_addr;
      wr_data   = {STORE_W'($signed(req_tdata[2*SAMPLE_W-1:SAMPLE_W])),
                   STORE_W'($signed(req_tdata[SAMPLE_W-1:0]))};
      rd_a_addr = j_addr;
      case (state_ff)
         S_LOAD: begin
            wr_en = req_fire;
         end
         S_WRK: begin
            wr_en   = 1'b1;
            wr_addr = k_addr;
            wr_data = {out_k_im, out_k_re};
         end
         S_WRJ: begin
            wr_en   = 1'b1;
            wr_addr = j_addr;
            wr_data = {out_j_im, out_j_re};
         end
         S_ORD: begin
            rd_a_addr = idx_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      inverse_in = inverse_ff;
      size_in    = size_ff;
      lg_in      = lg_ff;
      stage_in   = stage_ff;
      pos_in     = pos_ff;
      bf_in      = bf_ff;
      idx_in     = idx_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_INVERSE_MODE) begin
            inverse_in = csr_data[0];
         end else if (csr_index == CSR_SIZE_LOG2) begin
            size_in = csr_data;
         end
      end
      case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (req_tlast) begin
                  lg_in    = frame_lg;
                  stage_in = LG_W'(1);
                  bf_in    = '0;
                  pos_in   = '0;
                  state_in = S_RD;
               end else begin
                  pos_in = (pos_ff + PTR_W'(1)) & frame_mask;
               end
            end
         end
         S_RD:  state_in = S_MUL;
         S_MUL: state_in = S_SUM;
         S_SUM: state_in = S_WRK;
         S_WRK: state_in = S_WRJ;
         S_WRJ: begin
            if (bf_ff == last_bf) begin
               bf_in = '0;
               if (stage_ff == lg_ff) begin
                  idx_in   = '0;
                  state_in = S_ORD;
               end else begin
                  stage_in = stage_ff + LG_W'(1);
                  state_in = S_RD;
               end
            end else begin
               bf_in    = bf_ff + PTR_W'(1);
               state_in = S_RD;
            end
         end
         S_ORD: state_in = S_OUT;
         S_OUT: begin
            if (rsp_fire) begin
               if (rsp_tlast) begin
                  state_in = S_LOAD;
               end else begin
                  idx_in   = idx_ff + PTR_W'(1);
                  state_in = S_ORD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         inverse_ff <= 1'b0;
         size_ff    <= SIZE_RESET;
         lg_ff      <= LG_W'(LOG2_MAX);
         stage_ff   <= LG_W'(1);
         pos_ff     <= '0;
         bf_ff      <= '0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         inverse_ff <= inverse_in;
         size_ff    <= size_in;
         lg_ff      <= lg_in;
         stage_ff   <= stage_in;
         pos_ff     <= pos_in;
         bf_ff      <= bf_in;
         idx_ff     <= idx_in;
      end
   end

   // Working store: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (state_ff == S_RD || state_ff == S_ORD) begin
         rd_a_ff <= store_mem[rd_a_addr];
      end
      if (state_ff == S_RD) begin
         rd_b_ff <= store_mem[k_addr];
      end
   end

   // Shared butterfly datapath registers.
   always_ff @(posedge clock) begin
      if (state_ff == S_RD) begin
         tw_re_ff <= tw_re;
         tw_im_ff <= tw_im;
      end
      if (state_ff == S_MUL) begin
         p_rr_ff <= PROD_W'(tw_re_ff) * PROD_W'(xk_re);
         p_ii_ff <= PROD_W'(tw_im_ff) * PROD_W'(xk_im);
         p_ri_ff <= PROD_W'(tw_re_ff) * PROD_W'(xk_im);
         p_ir_ff <= PROD_W'(tw_im_ff) * PROD_W'(xk_re);
      end
      if (state_ff == S_SUM) begin
         t_re_ff <= T_W'(sum_re >>> TW_FRAC);
         t_im_ff <= T_W'(sum_im >>> TW_FRAC);
      end
   end

   // Loading and unloading never overlap.
   a_load_out_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a bin is presented");

   // A final sample starts the butterfly pass.
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> (state_ff == S_RD && stage_ff == LG_W'(1)))
      else $error("final sample did not start the transform");

   // The final bin returns the block to loading.
   a_last_bin: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("block not ready after the final bin");

   // Stage counter stays inside the latched frame size while transforming.
   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> (stage_ff >= LG_W'(1) && stage_ff <= lg_ff))
      else $error("stage counter out of range");

endmodule

// ===== test/fft_checker.sv =====
// Bin checker for the radix-2 FFT: watches all channels, predicts every bin, compares.
module fft_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [r2fft_pkg::REQ_W-1:0]      req_tdata,  // sample_re, sample_im
   input  logic                             req_tlast,  // sample_last
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [r2fft_pkg::RSP_W-1:0]      rsp_tdata,  // bin_re, bin_im, zero pad
   input  logic                             rsp_tlast,  // bin_last
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [r2fft_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [r2fft_pkg::CSR_DATA_W-1:0] csr_data,
   output int                               mismatch_count,
   output int                               bins_waiting
);
   import r2fft_pkg::*;

   typedef struct packed {
      store_type re;
      store_type im;
      logic      last;
   } spectrum_bin_type;

   store_type          acc_re [MAX_POINTS];
   store_type          acc_im [MAX_POINTS];
   int                 fill_pos;
   logic               inv_mode;
   logic [2:0]         size_code;
   int                 bin_index;
   spectrum_bin_type   bins_due [$];

   task automatic report(input string what);
      mismatch_count++;
      $display("mismatch at bin %0d: %s", bin_index, what);
   endtask

   function automatic int frame_order(input logic [2:0] code);
      if (code < 3'd1) begin
         return 1;
      end
      if (int'(code) > LOG2_MAX) begin
         return LOG2_MAX;
      end
      return int'(code);
   endfunction

   function automatic int flip_bits(input int v, input int nb);
      int r;
      int b;
      r = 0;
      for (b = 0; b < nb; b++) begin
         r = (r << 1) | ((v >> b) & 1);
      end
      return r;
   endfunction

   // Quarter-wave cosine, 2^30 scale, rounded to the twiddle fraction.
   function automatic longint twiddle_q(input int k);
      longint c;
      case (k)
         0:       c = 64'd1073741824;
         1:       c = 64'd1068571464;
         2:       c = 64'd1053110176;
         3:       c = 64'd1027506862;
         4:       c = 64'd992008094;
         5:       c = 64'd946955747;
         6:       c = 64'd892783698;
         7:       c = 64'd830013654;
         8:       c = 64'd759250125;
         9:       c = 64'd681174602;
         10:      c = 64'd596538995;
         11:      c = 64'd506158392;
         12:      c = 64'd410903207;
         13:      c = 64'd311690799;
         14:      c = 64'd209476638;
         15:      c = 64'd105245103;
         default: c = 64'd0;
      endcase
      return (c + (longint'(1) << (29 - TW_FRAC))) >>> (30 - TW_FRAC);
   endfunction

   function automatic store_type clip_store(input longint v);
      if (v > longint'(4194303)) begin
         return {1'b0, {(STORE_W-1){1'b1}}};
      end
      if (v < -longint'(4194304)) begin
         return {1'b1, {(STORE_W-1){1'b0}}};
      end
      return STORE_W'(v);
   endfunction

   // In-place decimation-in-time stages over the first 2^lg entries.
   task automatic butterfly_pass(input int lg);
      int     pts, stg, blk, half, stp, base, n, j, k, t;
      longint wr, wi, pr, pim, tr, ti, xr, xi;
      pts = 1 << lg;
      for (stg = 1; stg <= lg; stg++) begin
         blk  = 1 << stg;
         half = blk >> 1;
         stp  = 64 >> stg;
         for (base = 0; base < pts; base += blk) begin
            for (n = 0; n < half; n++) begin
               j = base + n;
               k = j + half;
               t = n * stp;
               if (t <= 16) begin
                  wr = twiddle_q(t);
                  wi = twiddle_q(16 - t);
               end else begin
                  wr = -twiddle_q(32 - t);
                  wi = twiddle_q(t - 16);
               end
               if (!inv_mode) begin
                  wi = -wi;
               end
               pr  = wr * longint'(acc_re[k]) - wi * longint'(acc_im[k]);
               pim = wr * longint'(acc_im[k]) + wi * longint'(acc_re[k]);
               tr  = (pr + (longint'(1) << (TW_FRAC - 1))) >>> TW_FRAC;
               ti  = (pim + (longint'(1) << (TW_FRAC - 1))) >>> TW_FRAC;
               xr  = longint'(acc_re[j]);
               xi  = longint'(acc_im[j]);
               acc_re[k] = clip_store(xr - tr);
               acc_im[k] = clip_store(xi - ti);
               acc_re[j] = clip_store(xr + tr);
               acc_im[j] = clip_store(xi + ti);
            end
         end
      end
   endtask

   task automatic take_sample(input logic [SAMPLE_W-1:0] re16, input logic [SAMPLE_W-1:0] im16,
                              input logic last);
      int               lg, pts, pos, addr, i;
      spectrum_bin_type b;
      lg   = frame_order(size_code);
      pts  = 1 << lg;
      pos  = fill_pos & (pts - 1);
      addr = flip_bits(pos, lg);
      acc_re[addr] = {{(STORE_W-SAMPLE_W){re16[SAMPLE_W-1]}}, re16};
      acc_im[addr] = {{(STORE_W-SAMPLE_W){im16[SAMPLE_W-1]}}, im16};
      if (!last) begin
         fill_pos = (pos + 1) & (pts - 1);
      end else begin
         butterfly_pass(lg);
         for (i = 0; i < pts; i++) begin
            b.re   = acc_re[i];
            b.im   = acc_im[i];
            b.last = (i == pts - 1);
            bins_due = {bins_due, b};
         end
         fill_pos = 0;
      end
   endtask

   task automatic check_bin;
      spectrum_bin_type want;
      store_type        got_re;
      store_type        got_im;
      got_re = rsp_tdata[STORE_W-1:0];
      got_im = rsp_tdata[2*STORE_W-1:STORE_W];
      if (bins_due.size() == 0) begin
         report("bin arrived with nothing expected");
      end else begin
         want = bins_due.pop_front();
         if (got_re !== want.re) begin
            report($sformatf("re got %0d want %0d", got_re, want.re));
         end
         if (got_im !== want.im) begin
            report($sformatf("im got %0d want %0d", got_im, want.im));
         end
         if (rsp_tlast !== want.last) begin
            report($sformatf("last got %b want %b", rsp_tlast, want.last));
         end
         if (rsp_tdata[RSP_W-1:2*STORE_W] !== '0) begin
            report("pad bits not zero");
         end
         bin_index = want.last ? 0 : bin_index + 1;
      end
   endtask

   // The store itself is left alone on reset, as in the block.
   always @(posedge clock) begin
      if (reset) begin
         fill_pos       = 0;
         inv_mode       = 1'b0;
         size_code      = SIZE_RESET;
         bin_index      = 0;
         mismatch_count = 0;
         bins_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INVERSE_MODE: inv_mode  = csr_data[0];
               CSR_SIZE_LOG2:    size_code = csr_data;
               default:          ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            take_sample(req_tdata[SAMPLE_W-1:0], req_tdata[2*SAMPLE_W-1:SAMPLE_W], req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_bin();
         end
      end
      bins_waiting = bins_due.size();
   end

endmodule

// ===== test/testbench.sv =====
// Top of the FFT test: clock, reset, sample frames, register writes, back-pressure, verdict.
module testbench;
   import r2fft_pkg::*;

   typedef enum int {
      FRAME_FULL,     // exactly N samples, last on the final one
      FRAME_EARLY,    // last arrives before N samples
      FRAME_OVERRUN   // more than N samples, position wraps, then last
   } frame_kind_type;

   // Quiet limit: nothing moves on any channel while a 64-point transform runs, and the
   // long receiver hold-off adds HOLD_SPAN on top; allow many times both.
   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_SPAN     = 2000;
   localparam int PHASE_ITEMS   = 30;
   localparam int TAIL_CYCLES   = 200;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata;   // sample_re, sample_im
   logic                   req_tlast;   // sample_last
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_W-1:0]       rsp_tdata;   // bin_re, bin_im, zero pad
   logic                   rsp_tlast;   // bin_last
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int   mismatch_count;
   int   bins_waiting;

   // Idle odds in percent, shared with the receiver process.
   int   tx_idle;
   int   rx_idle;
   // Long hold-off of the receiver, armed once by the stimulus.
   int   hold_span;
   int   held;
   logic hold_done;
   int   quiet;

   // Stimulus bookkeeping: frame size in force and how many entries hold data.
   int   frame_lg;
   int   ready_pts;
   int   item_total;

   radix2_complex_fft dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   fft_checker bin_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .bins_waiting   (bins_waiting)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Receiver: stall at random, or hold off for a long stretch once armed.
   always @(posedge clock) begin
      if (hold_span > 0 && !hold_done) begin
         rsp_tready <= 1'b0;
         held++;
         if (held >= hold_span) begin
            hold_done = 1'b1;
         end
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle);
      end
   end

   // Watchdog: end the run when no channel moves an item for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Offer one sample, after a random gap; return at the edge that accepts it.
   // Valid stays high on return so back-to-back items need no extra edge.
   task automatic send_sample(input logic [SAMPLE_W-1:0] re, input logic [SAMPLE_W-1:0] im,
                              input logic last);
      while ($urandom_range(0, 99) < tx_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {im, re};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      item_total++;
   endtask

   // Drop valid, wait until every expected bin is out, then let the block settle.
   // Look at the bin count on the falling edge so the checker has already updated it.
   task automatic drain_block;
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (bins_waiting != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      drain_block();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Write both registers and track the clamped frame size.
   task automatic configure(input logic inv, input logic [2:0] code);
      write_reg(CSR_INVERSE_MODE, {2'b00, inv});
      write_reg(CSR_SIZE_LOG2, code);
      if (code < 3'd1) begin
         frame_lg = 1;
      end else if (int'(code) > LOG2_MAX) begin
         frame_lg = LOG2_MAX;
      end else begin
         frame_lg = int'(code);
      end
   endtask

   // Mostly full-range random, with the extremes and zero mixed in.
   function automatic logic [SAMPLE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) begin
         return 16'h8000;
      end
      if (r < 12) begin
         return 16'h7FFF;
      end
      if (r < 15) begin
         return 16'h0000;
      end
      return 16'($urandom);
   endfunction

   // Early frames stay short; they only run where every entry already holds data.
   task automatic send_frame(input frame_kind_type kind);
      int pts, count, i;
      pts = 1 << frame_lg;
      case (kind)
         FRAME_EARLY:   count = $urandom_range(1, (pts - 1 < 8) ? pts - 1 : 8);
         FRAME_OVERRUN: count = pts + $urandom_range(1, pts);
         default:       count = pts;
      endcase
      for (i = 1; i <= count; i++) begin
         send_sample(pick_value(), pick_value(), i == count);
      end
      if (kind != FRAME_EARLY && pts > ready_pts) begin
         ready_pts = pts;
      end
   endtask

   initial begin
      int             phase, phase_start, frames, f, r, i;
      logic           first;
      frame_kind_type kind;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      rsp_tready <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      hold_span  = 0;
      held       = 0;
      hold_done  = 1'b0;
      quiet      = 0;
      ready_pts  = 0;
      item_total = 0;
      frame_lg   = LOG2_MAX;
      tx_idle    = 14;
      rx_idle    = 59;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: two-point frames at the sample extremes, the second with size code zero.
      configure(1'b0, 3'd1);
      send_sample(16'h7FFF, 16'h8000, 1'b0);
      send_sample(16'h8000, 16'h7FFF, 1'b1);
      ready_pts = 2;
      configure(1'b0, 3'd0);
      send_sample(16'h8000, 16'h8000, 1'b0);
      send_sample(16'h7FFF, 16'h7FFF, 1'b1);

      // Impulse into a four-point frame, then an early last that reuses the old bins.
      configure(1'b0, 3'd2);
      send_sample(16'h7FFF, 16'h0000, 1'b0);
      for (i = 1; i < 4; i++) begin
         send_sample(16'h0000, 16'h0000, i == 3);
      end
      ready_pts = 4;
      send_sample(16'h1234, 16'hEDCB, 1'b1);

      // Too many samples: three into a two-point frame, the position wraps.
      configure(1'b0, 3'd1);
      for (i = 0; i < 3; i++) begin
         send_sample(pick_value(), pick_value(), i == 2);
      end

      // Inverse eight-point frame with alternating extremes.
      configure(1'b1, 3'd3);
      for (i = 0; i < 8; i++) begin
         send_sample(i[0] ? 16'h8000 : 16'h7FFF, pick_value(), i == 7);
      end
      ready_pts = 8;

      // Size change in the middle of a frame: three samples at four points, finish at two.
      configure(1'b1, 3'd2);
      for (i = 0; i < 3; i++) begin
         send_sample(pick_value(), pick_value(), 1'b0);
      end
      configure(1'b1, 3'd1);
      send_sample(pick_value(), pick_value(), 1'b1);

      // Random frames in three idling phases.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle = 14;
               rx_idle = 59;
            end
            1: begin
               tx_idle = 59;
               rx_idle = 14;
            end
            default: begin
               tx_idle = 0;
               rx_idle = 0;
            end
         endcase
         phase_start = item_total;
         first       = 1'b1;
         while (item_total - phase_start < PHASE_ITEMS) begin
            // One full frame at size code 7 (clamped to the largest), later two short
            // inverse frames at the largest size; everything else stays small.
            if (first && phase == 0) begin
               configure(1'($urandom_range(0, 1)), 3'd7);
            end else if (first && phase == 2) begin
               configure(1'b1, 3'd6);
            end else if ($urandom_range(0, 99) < 85) begin
               configure(1'($urandom_range(0, 1)), 3'($urandom_range(0, 4)));
            end else begin
               configure(1'($urandom_range(0, 1)), 3'd5);
            end
            // The second frame of the held phase is offered while the receiver holds off.
            frames = first ? ((phase == 2) ? 2 : 1) : $urandom_range(1, 3);
            for (f = 0; f < frames; f++) begin
               r = $urandom_range(0, 99);
               if (first && phase == 0) begin
                  kind = FRAME_FULL;
               end else if (first && phase == 2) begin
                  kind = FRAME_EARLY;
               end else if (r < 20 && (1 << frame_lg) <= ready_pts) begin
                  kind = FRAME_EARLY;
               end else if (r < 35) begin
                  kind = FRAME_OVERRUN;
               end else begin
                  kind = FRAME_FULL;
               end
               send_frame(kind);
               // Hold the receiver off while the sender keeps offering the next frames.
               if (first && phase == 2) begin
                  hold_span = HOLD_SPAN;
               end
            end
            first = 1'b0;
         end
      end

      drain_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && bins_waiting == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
